FILE: rtl/prc_pkg.sv
// Package for the packet rule classifier: item layouts, rule word fields,
// codes and the per-rule match functions.
// No dependencies; used by every other file in rtl/.
`default_nettype none

package prc_pkg;

  // Field widths that the item layouts fix
  localparam int CNT_W      = 5;    // consulted count, 0..16
  localparam int HIT_W      = 4;    // rule index on the result side
  localparam int WORD_W     = 64;
  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 16;
  localparam int PROTO_W    = 3;
  localparam int S_TDATA_W  = 176;  // 170 bits of fields, padded to bytes
  localparam int M_TDATA_W  = 40;   // 37 bits of fields, padded to bytes
  localparam int PADDR_W    = 3;

  localparam logic [ADDR_W-1:0] ADDR_ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [PORT_W-1:0] FLOW_PORT_LIMIT = 16'd1024;

  // Action codes carried on s_tuser
  localparam logic ACT_CLASSIFY = 1'b0;
  localparam logic ACT_WRITE    = 1'b1;

  // Word select codes
  localparam logic [1:0] SEL_CTRL  = 2'd0;
  localparam logic [1:0] SEL_ADDR  = 2'd1;
  localparam logic [1:0] SEL_PORTS = 2'd2;

  // Rule protocol codes (packet side uses the same numbers)
  localparam logic [PROTO_W-1:0] PROTO_ANY  = 3'd0;
  localparam logic [PROTO_W-1:0] PROTO_IP   = 3'd1;
  localparam logic [PROTO_W-1:0] PROTO_TCP  = 3'd2;
  localparam logic [PROTO_W-1:0] PROTO_UDP  = 3'd3;
  localparam logic [PROTO_W-1:0] PROTO_ICMP = 3'd4;

  // Address modes
  localparam logic [1:0] AMODE_ANY    = 2'd0;
  localparam logic [1:0] AMODE_EXACT  = 2'd1;
  localparam logic [1:0] AMODE_PREFIX = 2'd2;

  // Register index of rules_in_use on the APB port
  localparam logic REG_RULES_IN_USE = 1'b0;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // One table entry as the memory holds it
  typedef struct packed {
    logic [WORD_W-1:0] ports;
    logic [WORD_W-1:0] addrs;
    logic [WORD_W-1:0] ctrl;
  } rule_t;

  // Header fields of a packet item
  typedef struct packed {
    logic [ADDR_W-1:0]  src_ip;
    logic [ADDR_W-1:0]  dst_ip;
    logic [PORT_W-1:0]  sport;
    logic [PORT_W-1:0]  dport;
    logic [PROTO_W-1:0] protocol;
    logic               tcp_ack;
  } pkt_t;

  // Outcome of comparing one rule with the packet
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] sid;
    logic              alert;
  } match_t;

  function automatic logic proto_ok(logic [PROTO_W-1:0] rp, logic [PROTO_W-1:0] pp);
    logic ok;
    ok = 1'b0;
    unique case (rp)
      PROTO_ANY:  ok = 1'b1;
      PROTO_IP:   ok = (pp != PROTO_ANY);
      PROTO_TCP:  ok = (pp == PROTO_TCP);
      PROTO_UDP:  ok = (pp == PROTO_UDP);
      PROTO_ICMP: ok = (pp == PROTO_ICMP);
      default:    ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic addr_ok(logic [1:0] mode, logic [5:0] plen,
                                   logic [ADDR_W-1:0] net, logic [ADDR_W-1:0] ip);
    logic [ADDR_W-1:0] mask;
    logic              ok;
    // keeps the top plen bits; plen 0 gives an empty mask
    mask = ~(ADDR_ALL_ONES >> plen);
    ok   = 1'b0;
    unique case (mode)
      AMODE_ANY:    ok = 1'b1;
      AMODE_EXACT:  ok = (ip == net);
      AMODE_PREFIX: ok = (plen <= 6'(ADDR_W)) && (net != '0) && (ip != '0) &&
                         ((ip & mask) == net);
      default:      ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic flow_ok(logic [3:0] fb, pkt_t p);
    logic ok;
    ok = (fb == 4'd0) ||
         (fb[0] && (p.protocol == PROTO_TCP) && p.tcp_ack) ||
         (fb[1] && (p.dport < FLOW_PORT_LIMIT)) ||
         (fb[2] && (p.sport < FLOW_PORT_LIMIT)) ||
         fb[3];
    return ok;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/prc_rule_mem.sv
// Rule table: one synchronous memory of three 64-bit lanes per entry,
// lane write enables, one registered read port. Depends on prc_pkg.
`default_nettype none

module prc_rule_mem
  import prc_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [1:0]        wr_sel,
  input  wire logic [WORD_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output rule_t                  rd_data
);

  rule_t mem [DEPTH];

  // Lane write; an unused select code leaves the entry alone
  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (wr_sel)
        SEL_CTRL:  mem[wr_addr].ctrl  <= wr_data;
        SEL_ADDR:  mem[wr_addr].addrs <= wr_data;
        SEL_PORTS: mem[wr_addr].ports <= wr_data;
        default: ;
      endcase
    end
  end

  // Registered read, held while the scan is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/prc_rule_match.sv
// Compares one rule entry with the held packet header and registers the
// outcome. Depends on prc_pkg.
`default_nettype none

module prc_rule_match
  import prc_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire logic rule_valid,
  input  rule_t     rule,
  input  pkt_t      pkt,
  output match_t    result
);

  logic   hit;
  match_t result_next;

  // Every condition of the rule has to hold
  always_comb begin
    hit = rule_valid && rule.ctrl[32] &&
          proto_ok(rule.ctrl[36:34], pkt.protocol) &&
          addr_ok(rule.ctrl[42:41], rule.ctrl[48:43], rule.addrs[31:0], pkt.src_ip) &&
          addr_ok(rule.ctrl[50:49], rule.ctrl[56:51], rule.addrs[63:32], pkt.dst_ip) &&
          (pkt.sport >= rule.ports[15:0])  && (pkt.sport <= rule.ports[31:16]) &&
          (pkt.dport >= rule.ports[47:32]) && (pkt.dport <= rule.ports[63:48]) &&
          flow_ok(rule.ctrl[40:37], pkt);
    result_next.hit   = hit;
    result_next.sid   = rule.ctrl[31:0];
    result_next.alert = rule.ctrl[33];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/packet_rule_classifier_top.sv
// Top level of the packet rule classifier: stream ports, APB register,
// scan sequencer and result register. Depends on prc_pkg, prc_rule_mem,
// prc_rule_match.
//
//  port group  | direction | contents
//  s_*         | in        | write items (rule words) and packet items
//  m_*         | out       | one result item per matching rule, or one empty
//  APB         | config    | rules_in_use at byte address 0
//
// A packet item scans entries 0..N-1, N = min(rules_in_use, table depth),
// one memory read per cycle while the output is not stalled, through a
// three-stage read/compare/emit pipeline.
// A result waits in the output register; while it is not taken the whole
// scan pipeline holds. Reset clears control state only; the table contents
// are undefined until written, and no clearing pass is run.
`default_nettype none

module packet_rule_classifier_top
  import prc_pkg::*;
#(
  parameter int MAX_RULES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // stream in
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // tdata from bit 0: rule_index, word_select, word_data, src_ip, dst_ip,
  // source port, destination port, protocol, tcp_ack, zero pad
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // tuser: action
  input  wire logic                 s_tuser,
  // stream out
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // tdata from bit 0: hit_index, sid, alert, zero pad
  output logic [M_TDATA_W-1:0]      m_tdata,
  // tuser: matched
  output logic                      m_tuser,
  output logic                      m_tlast,
  // APB configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // Entries reachable by the 4-bit rule index
  localparam int DEPTH = (MAX_RULES < 16) ? MAX_RULES : 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t             state;
  logic [CNT_W-1:0]   rules_in_use;
  logic [CNT_W-1:0]   count_eff;
  logic [CNT_W-1:0]   iss;
  logic               adv;
  logic               issue;
  logic               rd_en;
  logic               in_acc;
  logic               wr_en;
  logic               out_load;
  pkt_t               pkt;
  rule_t              rd_data;
  match_t             match_r;
  logic               v1, v2;
  logic               last1, last2;
  logic [HIT_W-1:0]   idx1, idx2;
  logic               pend_valid;
  logic [HIT_W-1:0]   pend_idx;
  logic [ADDR_W-1:0]  pend_sid;
  logic               pend_alert;

  // APB register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rules_in_use <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RULES_IN_USE)) begin
      rules_in_use <= pwdata[CNT_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_RULES_IN_USE) ? {27'd0, rules_in_use} : 32'd0;

  assign count_eff = (rules_in_use > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : rules_in_use;

  // Handshake and scan control
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign adv      = !m_tvalid || m_tready;
  assign issue    = (state == ST_SCAN) && (iss < count_eff);
  assign rd_en    = adv && issue;
  // Writes are taken only while idle, so a scan never overlaps a write
  assign wr_en    = in_acc && (s_tuser == ACT_WRITE) &&
                    ({1'b0, s_tdata[3:0]} < CNT_W'(DEPTH));
  // Output register is loaded by a pushed-out hit or by the final result
  assign out_load = adv && (((state == ST_SCAN) && v2 && match_r.hit && pend_valid) ||
                            (state == ST_FIN));

  prc_rule_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s_tdata[AW-1:0]),
    .wr_sel  (s_tdata[5:4]),
    .wr_data (s_tdata[69:6]),
    .rd_en   (rd_en),
    .rd_addr (iss[AW-1:0]),
    .rd_data (rd_data)
  );

  prc_rule_match u_match (
    .clk        (clk),
    .en         (adv),
    .rule_valid (v1),
    .rule       (rd_data),
    .pkt        (pkt),
    .result     (match_r)
  );

  // Packet header capture
  always_ff @(posedge clk) begin
    if (in_acc && (s_tuser == ACT_CLASSIFY)) begin
      pkt.src_ip   <= s_tdata[101:70];
      pkt.dst_ip   <= s_tdata[133:102];
      pkt.sport    <= s_tdata[149:134];
      pkt.dport    <= s_tdata[165:150];
      pkt.protocol <= s_tdata[168:166];
      pkt.tcp_ack  <= s_tdata[169];
    end
  end

  // Sequencer, held match and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      iss        <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (s_tuser == ACT_CLASSIFY)) begin
            iss   <= '0;
            v1    <= 1'b0;
            v2    <= 1'b0;
            state <= (count_eff == '0) ? ST_FIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (adv) begin
            if (issue) begin
              iss <= iss + CNT_W'(1);
            end
            v1    <= issue;
            idx1  <= iss[HIT_W-1:0];
            last1 <= (iss == count_eff - CNT_W'(1));
            v2    <= v1;
            idx2  <= idx1;
            last2 <= last1;
            // a new hit pushes the held one out, not yet marked last
            if (v2 && match_r.hit) begin
              if (pend_valid) begin
                m_tuser  <= 1'b1;
                m_tlast  <= 1'b0;
                m_tdata  <= {3'd0, pend_alert, pend_sid, pend_idx};
              end
              pend_valid <= 1'b1;
              pend_idx   <= idx2;
              pend_sid   <= match_r.sid;
              pend_alert <= match_r.alert;
            end
            if (v2 && last2) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          // final result: the held hit, or the empty result
          if (adv) begin
            m_tlast    <= 1'b1;
            m_tuser    <= pend_valid;
            m_tdata    <= pend_valid ? {3'd0, pend_alert, pend_sid, pend_idx} : '0;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The scan never reads past the consulted count
  a_iss_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (iss <= count_eff))
    else $error("scan index beyond consulted count");

  // Pipeline stages are empty outside a scan
  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN) |-> (!v1 && !v2))
    else $error("scan pipeline busy outside scan");

  // No hit is held between packets
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("held match left over after packet");

  // An empty result is always the packet's final result
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("empty result not marked last");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for packet_rule_classifier_top: rule-table writes and
// packet items in on the stream, matches checked against a built-in classifier.
// Depends on rtl/prc_pkg.sv and the classifier RTL; reads no files.
`default_nettype none

module tb;
  import prc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH   = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_CYCLES  = 400;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int MAX_REPORTS   = 10;

  localparam logic [1:0]         SEL_NONE   = 2'd3;  // ignored word select
  localparam logic [1:0]         AMODE_BAD  = 2'd3;  // address mode that never matches
  localparam logic [PROTO_W-1:0] PROTO_ODD  = 3'd5;  // counts as IP only
  localparam logic [3:0]         FLOW_EST       = 4'b0001;
  localparam logic [3:0]         FLOW_TO_SERVER = 4'b0010;
  localparam logic [3:0]         FLOW_TO_CLIENT = 4'b0100;
  localparam logic [3:0]         FLOW_BOTH      = 4'b1000;
  localparam logic [PADDR_W-1:0] RULES_ADDR = PADDR_W'(4 * int'(REG_RULES_IN_USE));

  // One stream item as driven
  typedef struct packed {
    logic              action;
    logic [3:0]        rule_index;
    logic [1:0]        word_select;
    logic [WORD_W-1:0] word_data;
    pkt_t              pkt;
  } stream_req_t;

  // One result item
  typedef struct packed {
    logic              matched;
    logic [HIT_W-1:0]  hit_index;
    logic [ADDR_W-1:0] sid;
    logic              alert;
    logic              last;
  } verdict_t;

  // Shadow rule table, classification and the queue of verdicts still owed
  class classifier_scoreboard;
    logic [WORD_W-1:0] ctrl_words [TABLE_DEPTH];
    logic [WORD_W-1:0] addr_words [TABLE_DEPTH];
    logic [WORD_W-1:0] port_words [TABLE_DEPTH];
    logic [CNT_W-1:0]  rules_in_use = '0;
    verdict_t          pending [$];
    int                mismatches = 0;

    function void flag(string what);
      if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endfunction

    function bit address_hits(logic [1:0] mode, logic [5:0] plen,
                              logic [ADDR_W-1:0] net, logic [ADDR_W-1:0] ip);
      logic [63:0] span;
      // top plen bits of the lower half form the mask
      span = 64'hFFFF_FFFF_0000_0000 >> plen;
      case (mode)
        AMODE_ANY:    return 1'b1;
        AMODE_EXACT:  return ip == net;
        AMODE_PREFIX: return (plen <= 6'd32) && (net != '0) && (ip != '0) &&
                             ((ip & span[31:0]) == net);
        default:      return 1'b0;
      endcase
    endfunction

    function bit entry_hits(int e, pkt_t p);
      logic [WORD_W-1:0]  c, a, w;
      logic [PROTO_W-1:0] rp;
      logic [3:0]         fl;
      bit                 proto_pass, flow_pass;
      c  = ctrl_words[e];
      a  = addr_words[e];
      w  = port_words[e];
      rp = c[36:34];
      fl = c[40:37];
      proto_pass = (rp == PROTO_ANY) || ((rp == PROTO_IP) && (p.protocol != PROTO_ANY)) ||
                   ((rp == PROTO_TCP || rp == PROTO_UDP || rp == PROTO_ICMP) &&
                    (p.protocol == rp));
      flow_pass  = (fl == 4'd0) ||
                   ((fl & FLOW_EST) != 0 && p.protocol == PROTO_TCP && p.tcp_ack) ||
                   ((fl & FLOW_TO_SERVER) != 0 && p.dport < FLOW_PORT_LIMIT) ||
                   ((fl & FLOW_TO_CLIENT) != 0 && p.sport < FLOW_PORT_LIMIT) ||
                   ((fl & FLOW_BOTH) != 0);
      return c[32] && proto_pass && flow_pass &&
             address_hits(c[42:41], c[48:43], a[31:0], p.src_ip) &&
             address_hits(c[50:49], c[56:51], a[63:32], p.dst_ip) &&
             p.sport >= w[15:0] && p.sport <= w[31:16] &&
             p.dport >= w[47:32] && p.dport <= w[63:48];
    endfunction

    // Accepted input item: update the table or queue the packet's verdicts
    function void note_item(stream_req_t r);
      int                     span, final_hit;
      bit [TABLE_DEPTH-1:0]   hit_set;
      verdict_t               v;
      if (r.action == ACT_WRITE) begin
        case (r.word_select)
          SEL_CTRL:  ctrl_words[r.rule_index] = r.word_data;
          SEL_ADDR:  addr_words[r.rule_index] = r.word_data;
          SEL_PORTS: port_words[r.rule_index] = r.word_data;
          default: ;
        endcase
        return;
      end
      span      = (rules_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(rules_in_use);
      hit_set   = '0;
      final_hit = -1;
      for (int e = 0; e < span; e++) begin
        if (entry_hits(e, r.pkt)) begin
          hit_set[e] = 1'b1;
          final_hit  = e;
        end
      end
      if (final_hit < 0) begin
        v = '{matched: 1'b0, hit_index: '0, sid: '0, alert: 1'b0, last: 1'b1};
        pending = {pending, v};
        return;
      end
      for (int e = 0; e <= final_hit; e++) begin
        if (hit_set[e]) begin
          v.matched   = 1'b1;
          v.hit_index = e[HIT_W-1:0];
          v.sid       = ctrl_words[e][31:0];
          v.alert     = ctrl_words[e][33];
          v.last      = (e == final_hit);
          pending = {pending, v};
        end
      end
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result matched=%0b idx=%0d sid=%h alert=%0b last=%0b",
                       got.matched, got.hit_index, got.sid, got.alert, got.last));
        return;
      end
      want = pending.pop_front();
      if (got.matched !== want.matched || got.hit_index !== want.hit_index ||
          got.sid !== want.sid || got.alert !== want.alert || got.last !== want.last)
        flag($sformatf({"expected matched=%0b idx=%0d sid=%h alert=%0b last=%0b, ",
                        "got matched=%0b idx=%0d sid=%h alert=%0b last=%0b"},
                       want.matched, want.hit_index, want.sid, want.alert, want.last,
                       got.matched, got.hit_index, got.sid, got.alert, got.last));
    endfunction
  endclass

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [PADDR_W-1:0]   paddr    = '0;
  logic [31:0]          pwdata   = '0;
  logic [31:0]          prdata;
  logic                 pready;

  classifier_scoreboard sb = new();
  bit       source_idle_on = 1'b1;
  bit       sink_idle_on   = 1'b1;
  bit       stall_trigger  = 1'b0;
  int       stall_left     = 0;
  int       cycle_count    = 0;
  bit [2:0] words_set [TABLE_DEPTH];

  packet_rule_classifier_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: check accepted items, random back-pressure, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        sb.check_result('{matched: m_tuser, hit_index: m_tdata[3:0], sid: m_tdata[35:4],
                          alert: m_tdata[36], last: m_tlast});
      if (stall_trigger) begin
        stall_left    = STALL_CYCLES;
        stall_trigger = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(sink_idle_on && $urandom_range(99) < 33);
      end
    end
  end

  function automatic logic [WORD_W-1:0] ctrl_word(logic en, logic alert, logic [31:0] sid,
      logic [2:0] proto, logic [3:0] flow, logic [1:0] sm, logic [5:0] sl,
      logic [1:0] dm, logic [5:0] dl);
    return {7'd0, dl, dm, sl, sm, flow, proto, alert, en, sid};
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(7))
      0:       return '0;
      1:       return ADDR_ALL_ONES;
      2:       return 32'h0A00_0001;
      3:       return 32'h0A00_0102;
      4:       return 32'hC0A8_0101;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PORT_W-1:0] rand_port();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd22;
      2:       return 16'd80;
      3:       return 16'd1023;
      4:       return 16'd1024;
      5:       return 16'd8080;
      6:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Address that a rule of this mode is likely to accept
  function automatic logic [ADDR_W-1:0] aim_addr(logic [1:0] mode, logic [5:0] plen,
                                                 logic [ADDR_W-1:0] net);
    logic [63:0] span;
    span = 64'hFFFF_FFFF_0000_0000 >> plen;
    if (mode == AMODE_EXACT) return net;
    if (mode == AMODE_PREFIX && plen <= 6'd32) return net | ($urandom & ~span[31:0]);
    return rand_addr();
  endfunction

  function automatic logic [PORT_W-1:0] aim_port(logic [PORT_W-1:0] lo, logic [PORT_W-1:0] hi);
    if (hi >= lo) return lo + 16'($urandom_range(int'(hi - lo)));
    return rand_port();
  endfunction

  // Random rule with biased fields so that matches are common
  task automatic make_rule(output logic [WORD_W-1:0] c, a, w);
    logic [1:0]  am  [2];
    logic [5:0]  pl  [2];
    logic [31:0] net [2];
    logic [15:0] lo  [2];
    logic [15:0] hi  [2];
    logic [15:0] t;
    logic [63:0] span;
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: am[k] = AMODE_ANY;
        4, 5, 6:    am[k] = AMODE_EXACT;
        7, 8:       am[k] = AMODE_PREFIX;
        default:    am[k] = AMODE_BAD;
      endcase
      pl[k]  = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32));
      span   = 64'hFFFF_FFFF_0000_0000 >> pl[k];
      net[k] = rand_addr();
      if (am[k] == AMODE_PREFIX && $urandom_range(5) != 0) net[k] = net[k] & span[31:0];
      lo[k] = rand_port();
      hi[k] = rand_port();
      if (lo[k] > hi[k] && $urandom_range(6) != 0) begin
        t     = lo[k];
        lo[k] = hi[k];
        hi[k] = t;
      end
      if ($urandom_range(5) == 0) begin
        lo[k] = 16'd0;
        hi[k] = 16'hFFFF;
      end
    end
    c = ctrl_word($urandom_range(9) != 0, 1'($urandom), $urandom,
                  ($urandom_range(7) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4)),
                  ($urandom_range(2) == 0) ? 4'($urandom) : 4'd0,
                  am[0], pl[0], am[1], pl[1]);
    c[63:57] = 7'($urandom);  // spare bits, ignored
    a = {net[1], net[0]};
    w = {hi[1], lo[1], hi[0], lo[0]};
  endtask

  // Offer one item, holding tvalid until it is taken
  task automatic send_item(stream_req_t r);
    if (source_idle_on) begin
      while ($urandom_range(99) < 33) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.action;
    s_tdata  <= {6'd0, r.pkt.tcp_ack, r.pkt.protocol, r.pkt.dport, r.pkt.sport,
                 r.pkt.dst_ip, r.pkt.src_ip, r.word_data, r.word_select, r.rule_index};
    do @(posedge clk); while (!s_tready);
    sb.note_item(r);
  endtask

  task automatic write_word(int e, logic [1:0] sel, logic [WORD_W-1:0] data);
    stream_req_t r;
    r.action      = ACT_WRITE;
    r.rule_index  = e[3:0];
    r.word_select = sel;
    r.word_data   = data;
    r.pkt         = '{$urandom, $urandom, 16'($urandom), 16'($urandom), 3'($urandom),
                      1'($urandom)};
    send_item(r);
    if (sel != SEL_NONE) words_set[e][sel] = 1'b1;
  endtask

  task automatic send_packet(pkt_t p);
    stream_req_t r;
    r.action      = ACT_CLASSIFY;
    r.rule_index  = 4'($urandom);
    r.word_select = 2'($urandom);
    r.word_data   = {$urandom, $urandom};
    r.pkt         = p;
    send_item(r);
  endtask

  // Drop tvalid, wait for every verdict, then let the scan pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write rules_in_use over APB, then read it back
  task automatic set_rules(logic [CNT_W-1:0] value);
    logic [31:0] junk;
    junk = $urandom;
    settle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= RULES_ADDR;
    pwdata  <= {junk[31:CNT_W], value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.rules_in_use = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(32 - CNT_W){1'b0}}, value})
      sb.flag($sformatf("rules_in_use read back %h, expected %h", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Every entry that a packet will read must have all three words written
  task automatic fill_table(int eff);
    logic [WORD_W-1:0] c, a, w;
    for (int e = 0; e < eff; e++) begin
      make_rule(c, a, w);
      if (!words_set[e][SEL_CTRL])  write_word(e, SEL_CTRL, c);
      if (!words_set[e][SEL_ADDR])  write_word(e, SEL_ADDR, a);
      if (!words_set[e][SEL_PORTS]) write_word(e, SEL_PORTS, w);
    end
  endtask

  // Mostly packets aimed at a consulted rule, some random packets and rule writes
  task automatic random_traffic(int n, int eff);
    int                e, k;
    logic [WORD_W-1:0] c, a, w, data;
    logic [1:0]        sel;
    pkt_t              p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        e = $urandom_range(TABLE_DEPTH - 1);
        make_rule(c, a, w);
        case ($urandom_range(9))
          0:          sel = SEL_NONE;
          1, 2, 3:    sel = SEL_CTRL;
          4, 5, 6:    sel = SEL_ADDR;
          default:    sel = SEL_PORTS;
        endcase
        case (sel)
          SEL_CTRL: data = c;
          SEL_ADDR: data = a;
          default:  data = w;
        endcase
        if (sel == SEL_NONE || $urandom_range(7) == 0) data = {$urandom, $urandom};
        write_word(e, sel, data);
      end else if (eff > 0 && $urandom_range(9) < 6) begin
        e = $urandom_range(eff - 1);
        c = sb.ctrl_words[e];
        a = sb.addr_words[e];
        w = sb.port_words[e];
        p.src_ip   = aim_addr(c[42:41], c[48:43], a[31:0]);
        p.dst_ip   = aim_addr(c[50:49], c[56:51], a[63:32]);
        p.sport    = aim_port(w[15:0], w[31:16]);
        p.dport    = aim_port(w[47:32], w[63:48]);
        case (c[36:34])
          PROTO_ANY:                        p.protocol = 3'($urandom_range(7));
          PROTO_IP:                         p.protocol = 3'($urandom_range(7, 1));
          PROTO_TCP, PROTO_UDP, PROTO_ICMP: p.protocol = c[36:34];
          default:                          p.protocol = 3'($urandom_range(7));
        endcase
        p.tcp_ack = 1'($urandom);
        // near misses
        if ($urandom_range(4) == 0) begin
          k = $urandom_range(31);
          p.src_ip[k] = ~p.src_ip[k];
        end
        if ($urandom_range(6) == 0) begin
          k = $urandom_range(15);
          p.dport[k] = ~p.dport[k];
        end
        send_packet(p);
      end else begin
        send_packet('{rand_addr(), rand_addr(), rand_port(), rand_port(),
                      3'($urandom_range(7)), 1'($urandom)});
      end
    end
  endtask

  // Main sequence
  initial begin
    int unsigned levels [9];
    int          eff;
    levels = '{1, 16, 0, 31, 0, 16, 0, 17, 3};
    levels[2] = $urandom_range(2, 15);
    levels[6] = $urandom_range(18, 30);
    foreach (words_set[e]) words_set[e] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: nothing consulted after reset, so empty results only
    send_packet('{ADDR_ALL_ONES, ADDR_ALL_ONES, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1});
    send_packet('{32'd0, 32'd0, 16'd0, 16'd0, PROTO_ANY, 1'b0});
    write_word(0, SEL_NONE, {$urandom, $urandom});

    // Disabled entry, IP prefix/exact rule, established tcp rule, icmp /32 rule
    write_word(0, SEL_CTRL, ctrl_word(1'b0, 1'b1, 32'hDEAD_0000, PROTO_ANY, 4'd0,
                                      AMODE_ANY, 6'd0, AMODE_ANY, 6'd0));
    write_word(0, SEL_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
    write_word(0, SEL_PORTS, 64'hFFFF_0000_FFFF_0000);
    write_word(1, SEL_CTRL, ctrl_word(1'b1, 1'b1, 32'hFFFF_FFFF, PROTO_IP, FLOW_TO_SERVER,
                                      AMODE_PREFIX, 6'd8, AMODE_EXACT, 6'd0));
    write_word(1, SEL_ADDR, {32'hC0A8_0101, 32'h0A00_0000});
    write_word(1, SEL_PORTS, {16'd1023, 16'd0, 16'hFFFF, 16'd1024});
    write_word(2, SEL_CTRL, ctrl_word(1'b1, 1'b0, 32'h0000_1234, PROTO_TCP, FLOW_EST,
                                      AMODE_ANY, 6'd0, AMODE_ANY, 6'd0));
    write_word(2, SEL_ADDR, 64'd0);
    write_word(2, SEL_PORTS, 64'hFFFF_0000_FFFF_0000);
    write_word(3, SEL_CTRL, ctrl_word(1'b1, 1'b0, 32'd0, PROTO_ICMP, FLOW_BOTH,
                                      AMODE_PREFIX, 6'd32, AMODE_ANY, 6'd0));
    write_word(3, SEL_ADDR, {32'd0, ADDR_ALL_ONES});
    write_word(3, SEL_PORTS, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0});
    set_rules(5'd4);

    // two hits; odd protocol as IP; zero address against prefix; icmp /32;
    // unknown protocol against an IP rule; port bounds both sides
    send_packet('{32'h0A01_0203, 32'hC0A8_0101, 16'd5000, 16'd80, PROTO_TCP, 1'b1});
    send_packet('{32'h0A01_0203, 32'hC0A8_0101, 16'd5000, 16'd80, PROTO_ODD, 1'b1});
    send_packet('{32'd0, 32'hC0A8_0101, 16'd5000, 16'd2000, PROTO_TCP, 1'b0});
    send_packet('{ADDR_ALL_ONES, 32'h1234_5678, 16'hFFFF, 16'hFFFF, PROTO_ICMP, 1'b0});
    send_packet('{32'h0A00_0001, 32'hC0A8_0101, 16'd1024, 16'd1023, PROTO_ANY, 1'b0});
    send_packet('{32'h0A00_0001, 32'hC0A8_0101, 16'd1024, 16'd1023, PROTO_UDP, 1'b0});
    send_packet('{32'h0A00_0001, 32'hC0A8_0101, 16'd1024, 16'd1024, PROTO_UDP, 1'b0});

    // Random phases over several table sizes
    for (int ph = 0; ph < 9; ph++) begin
      set_rules(levels[ph][CNT_W-1:0]);
      eff = (levels[ph] > TABLE_DEPTH) ? TABLE_DEPTH : int'(levels[ph]);
      fill_table(eff);
      source_idle_on = (ph != 3);
      sink_idle_on   = (ph != 3);
      if (ph == 5) stall_trigger = 1'b1;
      random_traffic(46, eff);
    end

    settle();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/prc_pkg.sv
rtl/prc_rule_mem.sv
rtl/prc_rule_match.sv
rtl/packet_rule_classifier_top.sv
test/tb.sv
